@@ sv/glyph_color_expander_top_macros.svh @@
// assertion macros used by the glyph color expander row sequencer
`ifndef GLYPH_COLOR_EXPANDER_TOP_MACROS_SVH
`define GLYPH_COLOR_EXPANDER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define GCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gce assertion failed");

// next-cycle implication, disabled while reset is held
`define GCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gce assertion failed");

`endif

@@ sv/gce_pkg.sv @@
`default_nettype none

package gce_pkg;

    localparam int COLOR_W     = 24;
    localparam int PAL_ENTRIES = 16;
    localparam int PAL_ADDR_W  = 4;
    localparam int LEVEL_W     = 16;
    localparam int MASK_W      = 32;
    localparam int COUNT_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4;

    // function codes of an input request
    localparam logic FUNC_PAL_WR = 1'b0;
    localparam logic FUNC_ROW    = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG_INDEX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_INDEX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_ON   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOLD_ON      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDERLINE_ON = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_BOLD   = 3'd6;

    // default palette entries and the bright bank select
    localparam logic [PAL_ADDR_W-1:0] DEFAULT_FG_ENTRY = 4'd7;
    localparam logic [PAL_ADDR_W-1:0] DEFAULT_BG_ENTRY = 4'd0;
    localparam logic [PAL_ADDR_W-1:0] BOLD_BANK        = 4'h8;

    typedef logic [COLOR_W-1:0] t_color;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_FG,
        ST_RD_BOLD,
        ST_RD_BG,
        ST_CAP_BG,
        ST_EMIT
    } t_state;

    // rendition settings decoded from the config registers
    typedef struct packed {
        logic [PAL_ADDR_W-1:0] fg_sel;
        logic [PAL_ADDR_W-1:0] bg_sel;
        logic                  inverse;
        logic                  use_bold;
        logic                  fill_en;
    } t_rend;

    // keep the upper byte of each level, blue high and red low
    function automatic t_color pack_color(input logic [LEVEL_W-1:0] red,
                                          input logic [LEVEL_W-1:0] green,
                                          input logic [LEVEL_W-1:0] blue);
        pack_color = {blue[15:8], green[15:8], red[15:8]};
    endfunction

endpackage

`default_nettype wire

@@ sv/glyph_color_expander_top.sv @@
`default_nettype none

// Glyph color expander: turns a one-bit glyph row into 24-bit pixels, most
// significant mask bit first, using a 16-entry palette held in a one-port-read
// synchronous memory that reads as black until an entry is written. A palette
// write request does not stall the input. A row request, its pixel count
// saturated to MAX_ROW_PIXELS, first fetches the foreground, bold and
// background colors through the single palette read port in the states
// ST_RD_FG, ST_RD_BOLD, ST_RD_BG and ST_CAP_BG, then one pixel is loaded per
// cycle while the output register is free. A row with a pixel count of zero
// gives no pixels and does not stall the input. The input stalls while a row
// is in flight; the next request is taken at the edge after the final pixel
// enters the output register. Config writes are expected only when idle.
module glyph_color_expander_top #(
    parameter int MAX_ROW_PIXELS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [gce_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gce_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_func,
    input  wire logic [gce_pkg::PAL_ADDR_W-1:0] i_pal_index,
    input  wire logic [gce_pkg::LEVEL_W-1:0]    i_red_level,
    input  wire logic [gce_pkg::LEVEL_W-1:0]    i_green_level,
    input  wire logic [gce_pkg::LEVEL_W-1:0]    i_blue_level,
    input  wire logic [gce_pkg::MASK_W-1:0]     i_glyph_row,
    input  wire logic [gce_pkg::COUNT_W-1:0]    i_pixel_count,
    input  wire logic                           i_last_row,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [gce_pkg::COLOR_W-1:0]         o_pixel_color,
    output logic                                o_last_pixel
);
    import gce_pkg::*;

    logic [CFG_DATA_W-1:0] r_fg_index;
    logic [CFG_DATA_W-1:0] r_bg_index;
    logic                  r_inverse_on;
    logic                  r_bold_on;
    logic                  r_blink_on;
    logic                  r_underline_on;
    logic                  r_force_bold;

    t_rend                 rend;
    logic                  pal_we;
    logic [PAL_ADDR_W-1:0] rd_addr;
    t_color                rd_data;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_index     <= '0;
            r_bg_index     <= '0;
            r_inverse_on   <= 1'b0;
            r_bold_on      <= 1'b0;
            r_blink_on     <= 1'b0;
            r_underline_on <= 1'b0;
            r_force_bold   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FG_INDEX:     r_fg_index     <= i_cfg_data;
                CFG_BG_INDEX:     r_bg_index     <= i_cfg_data;
                CFG_INVERSE_ON:   r_inverse_on   <= i_cfg_data[0];
                CFG_BOLD_ON:      r_bold_on      <= i_cfg_data[0];
                CFG_BLINK_ON:     r_blink_on     <= i_cfg_data[0];
                CFG_UNDERLINE_ON: r_underline_on <= i_cfg_data[0];
                CFG_FORCE_BOLD:   r_force_bold   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // rendition decode, color number n selects entry n-1
    always_comb begin
        rend.fg_sel   = (r_fg_index == '0) ? DEFAULT_FG_ENTRY
                      : r_fg_index - PAL_ADDR_W'(1);
        rend.bg_sel   = (r_bg_index == '0) ? DEFAULT_BG_ENTRY
                      : r_bg_index - PAL_ADDR_W'(1);
        rend.inverse  = r_inverse_on;
        rend.use_bold = r_bold_on || r_blink_on || r_force_bold;
        rend.fill_en  = r_underline_on || r_blink_on;
    end

    // palette write on an accepted palette request
    assign pal_we = i_in_valid && !o_in_stall && (i_func == FUNC_PAL_WR);

    gce_pal_mem u_pal_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (pal_we),
        .i_waddr (i_pal_index),
        .i_wdata (pack_color(i_red_level, i_green_level, i_blue_level)),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    gce_row_seq #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_row_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_glyph_row   (i_glyph_row),
        .i_pixel_count (i_pixel_count),
        .i_last_row    (i_last_row),
        .i_rend        (rend),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

`default_nettype wire

@@ sv/gce_pal_mem.sv @@
`default_nettype none

module gce_pal_mem (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_we,
    input  wire logic [gce_pkg::PAL_ADDR_W-1:0] i_waddr,
    input  wire gce_pkg::t_color                i_wdata,
    input  wire logic [gce_pkg::PAL_ADDR_W-1:0] i_raddr,
    output gce_pkg::t_color                     o_rdata
);
    import gce_pkg::*;

    t_color                 r_mem [PAL_ENTRIES];
    logic [PAL_ENTRIES-1:0] r_valid;
    t_color                 r_rdata;
    logic                   r_rvalid;

    // palette storage, no reset on the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // per-entry written flags, an unwritten entry reads as black
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

`default_nettype wire

@@ sv/gce_row_seq.sv @@
`default_nettype none

module gce_row_seq #(
    parameter int MAX_ROW_PIXELS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_func,
    input  wire logic [gce_pkg::MASK_W-1:0]     i_glyph_row,
    input  wire logic [gce_pkg::COUNT_W-1:0]    i_pixel_count,
    input  wire logic                           i_last_row,
    input  wire gce_pkg::t_rend                 i_rend,
    output logic [gce_pkg::PAL_ADDR_W-1:0]      o_rd_addr,
    input  wire gce_pkg::t_color                i_rd_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output gce_pkg::t_color                     o_pixel_color,
    output logic                                o_last_pixel
);
    import gce_pkg::*;

    `include "glyph_color_expander_top_macros.svh"

    localparam int CNT_W = $clog2(MAX_ROW_PIXELS + 1);

    t_state               r_state;
    t_state               n_state;
    logic [MASK_W-1:0]    r_mask;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_fill;
    t_color               r_fg;
    t_color               r_bold;
    t_color               r_bg;
    logic                 r_out_valid;
    t_color               r_pixel_color;
    logic                 r_last_pixel;

    logic                 in_accept;
    logic                 row_start;
    logic [CNT_W-1:0]     sat_count;
    logic                 slot_free;
    logic                 load_pixel;
    t_color               pixel_color;

    assign in_accept = i_in_valid && !o_in_stall;
    assign sat_count = (i_pixel_count > COUNT_W'(MAX_ROW_PIXELS))
                     ? CNT_W'(MAX_ROW_PIXELS) : i_pixel_count[CNT_W-1:0];
    assign row_start = in_accept && (i_func == FUNC_ROW) && (sat_count != '0);
    assign slot_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (row_start) n_state = ST_RD_FG;
            ST_RD_FG:   n_state = ST_RD_BOLD;
            ST_RD_BOLD: n_state = ST_RD_BG;
            ST_RD_BG:   n_state = ST_CAP_BG;
            ST_CAP_BG:  n_state = ST_EMIT;
            ST_EMIT:    if (slot_free && r_cnt == CNT_W'(1)) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // state outputs: palette read address, input stall, pixel load
    always_comb begin
        o_rd_addr  = i_rend.fg_sel;
        o_in_stall = 1'b1;
        load_pixel = 1'b0;
        unique case (r_state)
            ST_IDLE:    o_in_stall = 1'b0;
            ST_RD_FG:   o_rd_addr  = i_rend.fg_sel;
            ST_RD_BOLD: o_rd_addr  = i_rend.fg_sel | BOLD_BANK;
            ST_RD_BG:   o_rd_addr  = i_rend.bg_sel;
            ST_CAP_BG:  o_rd_addr  = i_rend.bg_sel;
            ST_EMIT:    load_pixel = slot_free;
            default:    o_in_stall = 1'b1;
        endcase
    end

    // color for the leftmost remaining mask bit
    always_comb begin
        if (r_fill) begin
            pixel_color = r_fg;
        end else if (r_mask[MASK_W-1]) begin
            pixel_color = i_rend.use_bold ? r_bold : r_fg;
        end else begin
            pixel_color = r_bg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // row capture and shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (row_start) begin
            r_cnt <= sat_count;
        end else if (load_pixel) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_start) begin
            r_mask <= i_glyph_row;
            r_fill <= i_last_row && i_rend.fill_en;
        end else if (load_pixel) begin
            r_mask <= {r_mask[MASK_W-2:0], 1'b0};
        end
    end

    // palette read results, inverse swap when the background arrives
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_RD_BOLD: r_fg   <= i_rd_data;
            ST_RD_BG:   r_bold <= i_rd_data;
            ST_CAP_BG: begin
                if (i_rend.inverse) begin
                    r_fg <= i_rd_data;
                    r_bg <= r_fg;
                end else begin
                    r_bg <= i_rd_data;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_pixel) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_pixel) begin
            r_pixel_color <= pixel_color;
            r_last_pixel  <= (r_cnt == CNT_W'(1));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_color = r_pixel_color;
    assign o_last_pixel  = r_last_pixel;

    `GCE_ASSERT_NOW(a_emit_has_count, i_clk, i_rst_n, r_state == ST_EMIT, r_cnt != '0)
    `GCE_ASSERT_NEXT(a_row_starts_fetch, i_clk, i_rst_n, row_start, r_state == ST_RD_FG)
    `GCE_ASSERT_NEXT(a_last_load_ends_row, i_clk, i_rst_n,
        load_pixel && r_cnt == CNT_W'(1), r_state == ST_IDLE && r_last_pixel)

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gce_pkg::*;

    localparam int ROW_PIXELS_MAX  = 32;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int TAIL_CYCLES     = 40;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 38;
    localparam int NO_TYPED        = -1;

    // register index the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    // one line of the directed table: a register write or a request
    typedef struct {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  func;
        logic [PAL_ADDR_W-1:0] pal;
        logic [LEVEL_W-1:0]    red;
        logic [LEVEL_W-1:0]    green;
        logic [LEVEL_W-1:0]    blue;
        logic [MASK_W-1:0]     mask;
        logic [COUNT_W-1:0]    count;
        logic                  last;
        int                    typed_pixels;
        t_color                typed_color;
    } t_stim;

    typedef struct {
        t_color color;
        logic   last;
    } t_exp_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_stall;
    logic i_func;
    logic [PAL_ADDR_W-1:0] i_pal_index;
    logic [LEVEL_W-1:0]    i_red_level;
    logic [LEVEL_W-1:0]    i_green_level;
    logic [LEVEL_W-1:0]    i_blue_level;
    logic [MASK_W-1:0]     i_glyph_row;
    logic [COUNT_W-1:0]    i_pixel_count;
    logic i_last_row;
    logic o_out_valid;
    logic i_out_stall;
    logic [COLOR_W-1:0] o_pixel_color;
    logic o_last_pixel;

    // typed-in expectation travelling with the request
    int     req_typed_pixels;
    t_color req_typed_color;

    // shadow of the block's palette and rendition registers
    t_color palette_mirror [PAL_ENTRIES];
    logic [3:0] fg_num;
    logic [3:0] bg_num;
    logic inv_on;
    logic bold_set;
    logic blink_set;
    logic uline_set;
    logic fbold_set;

    t_exp_pixel expected_pixels [$];
    t_stim      directed_steps [$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         send_idle_pct;
    int         recv_stall_pct;
    logic       want_holdoff;

    glyph_color_expander_top #(.MAX_ROW_PIXELS(ROW_PIXELS_MAX)) i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
        mismatches++;
    endtask

    // expected pixels of one glyph row under the current rendition
    function automatic void expand_row(input logic [MASK_W-1:0] mask_in,
                                       input logic [COUNT_W-1:0] count_in,
                                       input logic last_in);
        logic [PAL_ADDR_W-1:0] fsel;
        t_color fg, bg, bright, swap, c;
        logic [MASK_W-1:0] mask;
        logic fill, use_bold;
        int n;
        fsel   = (fg_num == 4'd0) ? DEFAULT_FG_ENTRY : fg_num - 4'd1;
        fg     = palette_mirror[fsel];
        bright = palette_mirror[fsel | BOLD_BANK];
        bg     = palette_mirror[(bg_num == 4'd0) ? DEFAULT_BG_ENTRY : bg_num - 4'd1];
        if (inv_on) begin
            swap = fg;
            fg   = bg;
            bg   = swap;
        end
        n        = (count_in > ROW_PIXELS_MAX) ? ROW_PIXELS_MAX : int'(count_in);
        fill     = last_in && (uline_set || blink_set);
        use_bold = bold_set || blink_set || fbold_set;
        mask     = mask_in;
        for (int k = 0; k < n; k++) begin
            if (fill)
                c = fg;
            else if (mask[MASK_W-1])
                c = use_bold ? bright : fg;
            else
                c = bg;
            mask = mask << 1;
            expected_pixels.push_back('{color: c, last: (k == n - 1)});
        end
    endfunction

    // scoreboard: pixels checked first, then the request taken at the same edge
    always @(posedge i_clk) begin
        t_exp_pixel head;
        if (!i_rst_n) begin
            foreach (palette_mirror[e]) palette_mirror[e] = '0;
            fg_num    = '0;
            bg_num    = '0;
            inv_on    = 1'b0;
            bold_set  = 1'b0;
            blink_set = 1'b0;
            uline_set = 1'b0;
            fbold_set = 1'b0;
            expected_pixels.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("pixel with no request pending", '0,
                                    32'(o_pixel_color));
                end else begin
                    head = expected_pixels.pop_front();
                    if (o_pixel_color !== head.color)
                        report_mismatch("pixel_color", 32'(head.color),
                                        32'(o_pixel_color));
                    if (o_last_pixel !== head.last)
                        report_mismatch("last_pixel", 32'(head.last), 32'(o_last_pixel));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                if (i_func == FUNC_PAL_WR) begin
                    palette_mirror[i_pal_index] =
                        {i_blue_level[15:8], i_green_level[15:8], i_red_level[15:8]};
                end else if (req_typed_pixels != NO_TYPED) begin
                    for (int n = 0; n < req_typed_pixels; n++)
                        expected_pixels.push_back('{color: req_typed_color,
                                                    last: (n == req_typed_pixels - 1)});
                end else begin
                    expand_row(i_glyph_row, i_pixel_count, i_last_row);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FG_INDEX:     fg_num    = i_cfg_data;
                    CFG_BG_INDEX:     bg_num    = i_cfg_data;
                    CFG_INVERSE_ON:   inv_on    = i_cfg_data[0];
                    CFG_BOLD_ON:      bold_set  = i_cfg_data[0];
                    CFG_BLINK_ON:     blink_set = i_cfg_data[0];
                    CFG_UNDERLINE_ON: uline_set = i_cfg_data[0];
                    CFG_FORCE_BOLD:   fbold_set = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // watchdog on cycles with no transfer on any port
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // output side: random stall, plus one long hold-off when asked
    initial begin
        int   holdoff_left;
        logic holdoff_done;
        i_out_stall  = 1'b0;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_out_stall <= 1'b1;
            end else if (want_holdoff && !holdoff_done) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function automatic void add_row(input logic [MASK_W-1:0] mask,
                                    input logic [COUNT_W-1:0] count, input logic last,
                                    input int typed_pixels, input t_color typed_color);
        t_stim s;
        s = '{default: '0};
        s.func         = FUNC_ROW;
        s.mask         = mask;
        s.count        = count;
        s.last         = last;
        s.typed_pixels = typed_pixels;
        s.typed_color  = typed_color;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_pal(input logic [PAL_ADDR_W-1:0] pal,
                                    input logic [LEVEL_W-1:0] red,
                                    input logic [LEVEL_W-1:0] green,
                                    input logic [LEVEL_W-1:0] blue);
        t_stim s;
        s = '{default: '0};
        s.func         = FUNC_PAL_WR;
        s.pal          = pal;
        s.red          = red;
        s.green        = green;
        s.blue         = blue;
        s.typed_pixels = NO_TYPED;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        t_stim s;
        s = '{default: '0};
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        directed_steps.push_back(s);
    endfunction

    function automatic logic [LEVEL_W-1:0] rand_level();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return LEVEL_W'($urandom_range(65535));
        endcase
    endfunction

    // hold the request until the block takes it
    task automatic send_request(input t_stim s);
        i_in_valid       <= 1'b1;
        i_func           <= s.func;
        i_pal_index      <= s.pal;
        i_red_level      <= s.red;
        i_green_level    <= s.green;
        i_blue_level     <= s.blue;
        i_glyph_row      <= s.mask;
        i_pixel_count    <= s.count;
        i_last_row       <= s.last;
        req_typed_pixels <= s.typed_pixels;
        req_typed_color  <= s.typed_color;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // stop offering, let every pending pixel out, then let the block settle
    task automatic wait_for_pixels();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write; the caller lowers the write enable after a batch
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_rendition(input logic [3:0] fg, input logic [3:0] bg,
                                   input logic [3:0] inv, input logic [3:0] bold,
                                   input logic [3:0] blink, input logic [3:0] uline,
                                   input logic [3:0] fbold);
        wait_for_pixels();
        set_reg(CFG_FG_INDEX, fg);
        set_reg(CFG_BG_INDEX, bg);
        set_reg(CFG_INVERSE_ON, inv);
        set_reg(CFG_BOLD_ON, bold);
        set_reg(CFG_BLINK_ON, blink);
        set_reg(CFG_UNDERLINE_ON, uline);
        set_reg(CFG_FORCE_BOLD, fbold);
        set_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(15)));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_stim s;
        logic  cfg_open;
        int    pick;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_func           = FUNC_PAL_WR;
        i_pal_index      = '0;
        i_red_level      = '0;
        i_green_level    = '0;
        i_blue_level     = '0;
        i_glyph_row      = '0;
        i_pixel_count    = '0;
        i_last_row       = 1'b0;
        req_typed_pixels = NO_TYPED;
        req_typed_color  = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        want_holdoff     = 1'b0;

        // cleared palette: everything black, long rows saturate, empty row is silent
        add_row(32'hffff_ffff, 8'd32, 1'b0, 32, 24'h000000);
        add_row(32'hffff_ffff, 8'd0, 1'b1, 0, 24'h000000);
        add_row(32'h0000_0000, 8'd255, 1'b1, 32, 24'h000000);
        add_row(32'h5555_aaaa, 8'd33, 1'b0, 32, 24'h000000);
        add_row(32'h8000_0000, 8'd1, 1'b0, 1, 24'h000000);
        // white default foreground against the still-black background
        add_pal(4'd7, 16'hffff, 16'hffff, 16'hffff);
        add_row(32'hffff_ffff, 8'd32, 1'b0, 32, 24'hffffff);
        add_row(32'h0000_0000, 8'd8, 1'b0, 8, 24'h000000);
        // distinct colors so each selection path shows up
        add_pal(4'd0, 16'h12ab, 16'h34cd, 16'h56ef);
        add_pal(4'd15, 16'h00ff, 16'hff00, 16'h8000);
        add_pal(4'd8, 16'hffff, 16'h0000, 16'h0000);
        add_pal(4'd14, 16'h0000, 16'hffff, 16'h00ff);
        add_row(32'ha5a5_f00f, 8'd16, 1'b0, NO_TYPED, '0);
        add_cfg(CFG_BOLD_ON, 4'd1);
        add_row(32'hf0f0_f0f0, 8'd32, 1'b0, NO_TYPED, '0);
        // blink: bold for set pixels, fill on the bottom row
        add_cfg(CFG_BOLD_ON, 4'd0);
        add_cfg(CFG_BLINK_ON, 4'd1);
        add_row(32'h0f0f_0f0f, 8'd12, 1'b1, NO_TYPED, '0);
        add_row(32'h0f0f_0f0f, 8'd12, 1'b0, NO_TYPED, '0);
        // underline fill only on the bottom row
        add_cfg(CFG_BLINK_ON, 4'd0);
        add_cfg(CFG_UNDERLINE_ON, 4'd1);
        add_row(32'h3c3c_3c3c, 8'd10, 1'b1, NO_TYPED, '0);
        add_row(32'h3c3c_3c3c, 8'd10, 1'b0, NO_TYPED, '0);
        // inverse swaps fg and bg but not the bold color
        add_cfg(CFG_UNDERLINE_ON, 4'd0);
        add_cfg(CFG_FORCE_BOLD, 4'd1);
        add_cfg(CFG_INVERSE_ON, 4'd1);
        add_row(32'hc3c3_c3c3, 8'd12, 1'b0, NO_TYPED, '0);
        // color numbers of eight and above
        add_cfg(CFG_FG_INDEX, 4'd15);
        add_cfg(CFG_BG_INDEX, 4'd15);
        add_row(32'hcafe_f00d, 8'd24, 1'b0, NO_TYPED, '0);
        add_cfg(CFG_FG_INDEX, 4'd8);
        add_cfg(CFG_BG_INDEX, 4'd8);
        add_row(32'h1234_5678, 8'd20, 1'b1, NO_TYPED, '0);
        // undecoded index must leave the rendition alone
        add_cfg(CFG_SPARE, 4'd15);
        add_row(32'h8765_4321, 8'd9, 1'b0, NO_TYPED, '0);
        add_cfg(CFG_INVERSE_ON, 4'd0);
        add_cfg(CFG_FORCE_BOLD, 4'd0);
        add_row(32'hdead_beef, 8'd7, 1'b1, NO_TYPED, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        cfg_open = 1'b0;
        foreach (directed_steps[k]) begin
            if (directed_steps[k].is_cfg) begin
                if (!cfg_open) wait_for_pixels();
                set_reg(directed_steps[k].reg_idx, directed_steps[k].reg_val);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) i_cfg_we <= 1'b0;
                cfg_open = 1'b0;
                send_request(directed_steps[k]);
            end
        end

        // random phases, each under its own rendition and idling pattern
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       apply_rendition(4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
                1:       apply_rendition(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15);
                2:       apply_rendition(4'd8, 4'd8, 4'd1, 4'd0, 4'd1, 4'd0, 4'd0);
                default: apply_rendition(4'($urandom_range(15)), 4'($urandom_range(15)),
                                         4'($urandom_range(15)), 4'($urandom_range(15)),
                                         4'($urandom_range(15)), 4'($urandom_range(15)),
                                         4'($urandom_range(15)));
            endcase
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            // long output hold-off while requests keep coming
            want_holdoff = (phase == 4);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (phase == 5 && k == ITEMS_PER_PHASE / 2) wait_for_pixels();
                while ($urandom_range(99) < send_idle_pct) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                end
                s = '{default: '0};
                s.typed_pixels = NO_TYPED;
                s.func  = ($urandom_range(99) < 25) ? FUNC_PAL_WR : FUNC_ROW;
                s.pal   = PAL_ADDR_W'($urandom_range(15));
                s.red   = rand_level();
                s.green = rand_level();
                s.blue  = rand_level();
                case ($urandom_range(7))
                    0:       s.mask = '0;
                    1:       s.mask = '1;
                    default: s.mask = $urandom;
                endcase
                // mostly character-cell widths, a few empty and overlong rows
                pick = $urandom_range(99);
                if (pick < 5)
                    s.count = '0;
                else if (pick < 15)
                    s.count = COUNT_W'($urandom_range(255, 33));
                else if (pick < 25)
                    s.count = COUNT_W'(ROW_PIXELS_MAX);
                else
                    s.count = COUNT_W'($urandom_range(12, 1));
                s.last = 1'($urandom_range(1));
                send_request(s);
            end
        end

        wait_for_pixels();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/gce_pkg.sv
sv/gce_pal_mem.sv
sv/gce_row_seq.sv
sv/glyph_color_expander_top.sv
tb/testbench.sv
